### rtl/core/soe_pkg.sv
// Shared types and constants for the set operation engine.
// No dependencies; imported by every module of the block.
package soe_pkg;

   localparam int MAX_ELEMS = 32;
   localparam int ADDR_W    = $clog2(MAX_ELEMS);
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

   // Actions carried by an input beat
   localparam logic [2:0] ACT_LOAD_A = 3'd0;
   localparam logic [2:0] ACT_LOAD_B = 3'd1;
   localparam logic [2:0] ACT_QUERY  = 3'd2;
   localparam logic [2:0] ACT_RUN    = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   // Operation modes
   localparam logic [1:0] MODE_UNION = 2'd0;
   localparam logic [1:0] MODE_INTER = 2'd1;
   localparam logic [1:0] MODE_DIFF  = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_ELEM     = 2'd0;
   localparam logic [1:0] KIND_MEMBER   = 2'd1;
   localparam logic [1:0] KIND_EMPTY    = 2'd2;
   localparam logic [1:0] KIND_OVERFLOW = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_RD,
      ST_SORT_INS,
      ST_LIST,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SCAN_DEC,
      ST_QRY_RD,
      ST_QRY_CMP,
      ST_FIN
   } state_type;

   // Control broadcast to every sorting cell
   typedef struct packed {
      logic clear;
      logic insert;
      logic compare;
   } cell_ctl_type;

endpackage

### rtl/core/soe_cell.sv
// One cell of the sorting row: holds one element of the sorted set.
// Depends on soe_pkg for the control struct.
module soe_cell import soe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic signed [31:0]  ins_value,
   input  logic signed [31:0]  target,
   input  logic signed [31:0]  prev_value,
   input  logic                prev_valid,
   input  logic                prev_lt,
   output logic signed [31:0]  value,
   output logic                valid,
   output logic                lt,
   output logic                match
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               match_ff, match_in;

   // an empty cell counts as plus infinity
   assign lt = !valid_ff || (ins_value < value_ff);

   // shift right behind the insertion point, take the new beat at it
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         if (prev_lt) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else if (lt) begin
            value_in = ins_value;
            valid_in = 1'b1;
         end
      end
      if (ctl.compare) begin
         match_in = valid_ff && (value_ff == target);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

### rtl/core/set_operation_engine_core.sv
// Top level of the set operation engine: stores, sequencer and output register.
// Depends on soe_pkg and soe_cell.
//
// Loads that fit, clears and unknown actions complete in the idle state. A
// membership query scans set A element by element from its one read port (read,
// then compare). A run first inserts the smaller set (set B for difference)
// into a row of sorting cells element by element (store read, then insert),
// then lists the sorted set for union, then tests each element of the other set
// (read, parallel compare in every cell, decide); a final state delivers the last
// beat. Output backpressure adds stall cycles. Results leave through a one-beat
// output register, with one result held back so the last beat can be marked.
module set_operation_engine_core import soe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_item_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic signed [31:0] rsp_elem_value,
   output logic               rsp_is_member,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_data
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in, count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [CNT_W-1:0] ns_ff, ns_in, nb_ff, nb_in;
   logic [1:0]  mode_ff;
   logic        small_a_ff, small_a_in;
   logic signed [31:0] qval_ff, qval_in, scan_val_ff, scan_val_in;
   logic        hit_ff, hit_in;
   logic        pend_valid_ff, pend_valid_in, pend_member_ff, pend_member_in;
   logic [1:0]  pend_kind_ff, pend_kind_in;
   logic signed [31:0] pend_value_ff, pend_value_in;
   logic        out_valid_ff, out_valid_in, out_member_ff, out_member_in;
   logic        out_last_ff, out_last_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic signed [31:0] out_value_ff, out_value_in;

   logic signed [31:0] mem_a [MAX_ELEMS];
   logic signed [31:0] mem_b [MAX_ELEMS];
   logic signed [31:0] rdata_a_ff, rdata_b_ff, rdata_small, rdata_big;
   logic        wr_a, wr_b;

   cell_ctl_type       ctl;
   logic signed [31:0] cell_value [MAX_ELEMS];
   logic [MAX_ELEMS-1:0] cell_valid, cell_lt, cell_match;

   logic        accept, out_free, push, push_member, push_last;
   logic [1:0]  push_kind;
   logic signed [31:0] push_value;
   logic        any_match, emit;
   logic [CNT_W-1:0] idx_inc;

   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign idx_inc   = idx_ff + 1'b1;
   assign any_match = |cell_match;
   assign rdata_small = small_a_ff ? rdata_a_ff : rdata_b_ff;
   assign rdata_big   = small_a_ff ? rdata_b_ff : rdata_a_ff;
   assign emit = (mode_ff == MODE_INTER) ? any_match : !any_match;

   // stores: write on load, read at the running index
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[count_a_ff[ADDR_W-1:0]] <= req_item_value;
      end
      if (wr_b) begin
         mem_b[count_b_ff[ADDR_W-1:0]] <= req_item_value;
      end
      rdata_a_ff <= mem_a[idx_ff[ADDR_W-1:0]];
      rdata_b_ff <= mem_b[idx_ff[ADDR_W-1:0]];
   end

   // sorting row
   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      logic signed [31:0] pv;
      logic               pvld, plt;
      if (i == 0) begin : g_head
         assign pv   = '0;
         assign pvld = 1'b0;
         assign plt  = 1'b0;
      end else begin : g_body
         assign pv   = cell_value[i-1];
         assign pvld = cell_valid[i-1];
         assign plt  = cell_lt[i-1];
      end
      soe_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .ins_value  (rdata_small),
         .target     (rdata_big),
         .prev_value (pv),
         .prev_valid (pvld),
         .prev_lt    (plt),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .lt         (cell_lt[i]),
         .match      (cell_match[i])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      ns_in = ns_ff;
      nb_in = nb_ff;
      small_a_in = small_a_ff;
      qval_in = qval_ff;
      hit_in = hit_ff;
      scan_val_in = scan_val_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in = pend_kind_ff;
      pend_value_in = pend_value_ff;
      pend_member_in = pend_member_ff;
      wr_a = 1'b0;
      wr_b = 1'b0;
      ctl = '0;
      push = 1'b0;
      push_kind = pend_kind_ff;
      push_value = pend_value_ff;
      push_member = pend_member_ff;
      push_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               unique case (req_action)
                  ACT_LOAD_A: begin
                     if (count_a_ff < CNT_W'(MAX_ELEMS)) begin
                        wr_a = 1'b1;
                        count_a_in = count_a_ff + 1'b1;
                     end else begin
                        pend_valid_in = 1'b1;
                        pend_kind_in = KIND_OVERFLOW;
                        pend_value_in = '0;
                        pend_member_in = 1'b0;
                        state_in = ST_FIN;
                     end
                  end
                  ACT_LOAD_B: begin
                     if (count_b_ff < CNT_W'(MAX_ELEMS)) begin
                        wr_b = 1'b1;
                        count_b_in = count_b_ff + 1'b1;
                     end else begin
                        pend_valid_in = 1'b1;
                        pend_kind_in = KIND_OVERFLOW;
                        pend_value_in = '0;
                        pend_member_in = 1'b0;
                        state_in = ST_FIN;
                     end
                  end
                  ACT_QUERY: begin
                     qval_in = req_item_value;
                     hit_in = 1'b0;
                     if (count_a_ff == '0) begin
                        pend_valid_in = 1'b1;
                        pend_kind_in = KIND_MEMBER;
                        pend_value_in = '0;
                        pend_member_in = 1'b0;
                        state_in = ST_FIN;
                     end else begin
                        state_in = ST_QRY_RD;
                     end
                  end
                  ACT_RUN: begin
                     ctl.clear = 1'b1;
                     if (mode_ff == MODE_DIFF) begin
                        small_a_in = 1'b0;
                        ns_in = count_b_ff;
                        nb_in = count_a_ff;
                        state_in = (count_b_ff != '0) ? ST_SORT_RD :
                                   (count_a_ff != '0) ? ST_SCAN_RD : ST_FIN;
                     end else if (mode_ff == MODE_UNION || mode_ff == MODE_INTER) begin
                        small_a_in = (count_a_ff <= count_b_ff);
                        ns_in = (count_a_ff <= count_b_ff) ? count_a_ff : count_b_ff;
                        nb_in = (count_a_ff <= count_b_ff) ? count_b_ff : count_a_ff;
                        if (((count_a_ff <= count_b_ff) ? count_a_ff : count_b_ff) != '0) begin
                           state_in = ST_SORT_RD;
                        end else if (((count_a_ff <= count_b_ff) ? count_b_ff : count_a_ff)
                                     != '0) begin
                           state_in = ST_SCAN_RD;
                        end else begin
                           state_in = ST_FIN;
                        end
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  ACT_CLEAR: begin
                     count_a_in = '0;
                     count_b_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SORT_RD: begin
            state_in = ST_SORT_INS;
         end
         ST_SORT_INS: begin
            ctl.insert = 1'b1;
            if (idx_inc == ns_ff) begin
               idx_in = '0;
               state_in = (mode_ff == MODE_UNION) ? ST_LIST :
                          (nb_ff != '0) ? ST_SCAN_RD : ST_FIN;
            end else begin
               idx_in = idx_inc;
               state_in = ST_SORT_RD;
            end
         end
         ST_LIST: begin
            // hold the new element back; release the previous one
            if (!pend_valid_ff || out_free) begin
               push = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_kind_in = KIND_ELEM;
               pend_value_in = cell_value[idx_ff[ADDR_W-1:0]];
               pend_member_in = 1'b0;
               if (idx_inc == ns_ff) begin
                  idx_in = '0;
                  state_in = (nb_ff != '0) ? ST_SCAN_RD : ST_FIN;
               end else begin
                  idx_in = idx_inc;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            ctl.compare = 1'b1;
            scan_val_in = rdata_big;
            state_in = ST_SCAN_DEC;
         end
         ST_SCAN_DEC: begin
            if (!(emit && pend_valid_ff) || out_free) begin
               if (emit) begin
                  push = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_kind_in = KIND_ELEM;
                  pend_value_in = scan_val_ff;
                  pend_member_in = 1'b0;
               end
               if (idx_inc == nb_ff) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in = idx_inc;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_QRY_RD: begin
            state_in = ST_QRY_CMP;
         end
         ST_QRY_CMP: begin
            if (idx_inc == count_a_ff) begin
               pend_valid_in = 1'b1;
               pend_kind_in = KIND_MEMBER;
               pend_value_in = '0;
               pend_member_in = hit_ff || (rdata_a_ff == qval_ff);
               state_in = ST_FIN;
            end else begin
               hit_in = hit_ff || (rdata_a_ff == qval_ff);
               idx_in = idx_inc;
               state_in = ST_QRY_RD;
            end
         end
         ST_FIN: begin
            // deliver the held result as the last beat, or an empty one
            push = 1'b1;
            push_last = 1'b1;
            if (!pend_valid_ff) begin
               push_kind = KIND_EMPTY;
               push_value = '0;
               push_member = 1'b0;
            end
            if (out_free) begin
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in = out_kind_ff;
      out_value_in = out_value_ff;
      out_member_in = out_member_ff;
      out_last_in = out_last_ff;
      if (push && out_free) begin
         out_valid_in = 1'b1;
         out_kind_in = push_kind;
         out_value_in = push_value;
         out_member_in = push_member;
         out_last_in = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_a_ff <= '0;
         count_b_ff <= '0;
         mode_ff <= MODE_UNION;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      ns_ff <= ns_in;
      nb_ff <= nb_in;
      small_a_ff <= small_a_in;
      qval_ff <= qval_in;
      hit_ff <= hit_in;
      scan_val_ff <= scan_val_in;
      pend_kind_ff <= pend_kind_in;
      pend_value_ff <= pend_value_in;
      pend_member_ff <= pend_member_in;
      out_kind_ff <= out_kind_in;
      out_value_ff <= out_value_in;
      out_member_ff <= out_member_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_elem_value = out_value_ff;
   assign rsp_is_member = out_member_ff;
   assign rsp_last_of_run = out_last_ff;

`ifndef SYNTHESIS
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("held result left over while idle");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CNT_W'(MAX_ELEMS)) && (count_b_ff <= CNT_W'(MAX_ELEMS)))
      else $error("set count beyond capacity");
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != KIND_ELEM) |-> (rsp_elem_value == 0))
      else $error("non-element beat carries a value");
   a_member_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_member |-> (rsp_result_kind == KIND_MEMBER) && rsp_last_of_run)
      else $error("membership flag on wrong beat");
`endif

endmodule

### test/tb_set_operation_engine_core.sv
// Testbench for set_operation_engine_core: directed and random beats checked
// against an in-bench predictor of the set stores. Depends on soe_pkg and the RTL.
module tb_set_operation_engine_core import soe_pkg::*;;

   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int LIMIT = 1_500_000;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic               member;
      logic               last;
   } outcome_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_action;
   logic signed [31:0] req_item_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_result_kind;
   logic signed [31:0] rsp_elem_value;
   logic               rsp_is_member;
   logic               rsp_last_of_run;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_data;

   // Predictor state
   logic signed [31:0] set_a [MAX_ELEMS];
   logic signed [31:0] set_b [MAX_ELEMS];
   int                 size_a;
   int                 size_b;
   logic [1:0]         op_mode;
   outcome_type        pending_results [$];

   int errors;
   int req_beats;
   int csr_beats;
   int cycles;
   int idle_pct;
   int stall_pct;

   set_operation_engine_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_item_value(req_item_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind), .rsp_elem_value(rsp_elem_value),
      .rsp_is_member(rsp_is_member), .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Membership of a value in the first n words of a list
   function automatic logic holds(logic signed [31:0] list [MAX_ELEMS], int n,
                                  logic signed [31:0] v);
      for (int i = 0; i < n; i++)
         if (list[i] == v) return 1'b1;
      return 1'b0;
   endfunction

   // Work out the results of one accepted beat and queue them
   task automatic predict_beat(logic [2:0] action, logic signed [31:0] v);
      outcome_type        res [$];
      outcome_type        o;
      logic signed [31:0] lesser [MAX_ELEMS];
      logic signed [31:0] big [MAX_ELEMS];
      logic signed [31:0] t;
      int                 ns;
      int                 nb;
      int                 j;
      o.value = '0; o.member = 1'b0; o.last = 1'b0;
      case (action)
         ACT_LOAD_A: begin
            if (size_a < MAX_ELEMS) begin
               set_a[size_a] = v; size_a++;
            end else begin
               o.kind = KIND_OVERFLOW; res.push_back(o);
            end
         end
         ACT_LOAD_B: begin
            if (size_b < MAX_ELEMS) begin
               set_b[size_b] = v; size_b++;
            end else begin
               o.kind = KIND_OVERFLOW; res.push_back(o);
            end
         end
         ACT_QUERY: begin
            o.kind = KIND_MEMBER; o.member = holds(set_a, size_a, v);
            res.push_back(o);
         end
         ACT_RUN: begin
            // Smaller set is sorted; A wins a tie. Difference always sorts B.
            if (op_mode == MODE_DIFF || size_a > size_b) begin
               lesser = set_b; ns = size_b; big = set_a; nb = size_a;
            end else begin
               lesser = set_a; ns = size_a; big = set_b; nb = size_b;
            end
            for (int i = 1; i < ns; i++) begin
               t = lesser[i]; j = i;
               while (j > 0 && t < lesser[j-1]) begin
                  lesser[j] = lesser[j-1]; j--;
               end
               lesser[j] = t;
            end
            o.kind = KIND_ELEM;
            if (op_mode == MODE_UNION) begin
               for (int i = 0; i < ns; i++) begin
                  o.value = lesser[i]; res.push_back(o);
               end
               for (int i = 0; i < nb; i++)
                  if (!holds(lesser, ns, big[i])) begin
                     o.value = big[i]; res.push_back(o);
                  end
            end else if (op_mode == MODE_INTER) begin
               for (int i = 0; i < nb; i++)
                  if (holds(lesser, ns, big[i])) begin
                     o.value = big[i]; res.push_back(o);
                  end
            end else if (op_mode == MODE_DIFF) begin
               for (int i = 0; i < size_a; i++)
                  if (!holds(lesser, ns, set_a[i])) begin
                     o.value = set_a[i]; res.push_back(o);
                  end
            end
            if (res.size() == 0) begin
               o.kind = KIND_EMPTY; o.value = '0; res.push_back(o);
            end
         end
         ACT_CLEAR: begin
            size_a = 0; size_b = 0;
         end
         default: ;
      endcase
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
      foreach (res[i]) pending_results.push_back(res[i]);
   endtask

   // Watch every beat at the rising edge: check results, then predict
   always @(posedge clock) begin
      outcome_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result beat kind %0d value %0d", $time,
                        rsp_result_kind, rsp_elem_value);
               errors++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_result_kind !== e.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, e.kind,
                           rsp_result_kind);
                  errors++;
               end
               if (rsp_elem_value !== e.value) begin
                  $display("%0t: value expected %0d actual %0d", $time, e.value,
                           rsp_elem_value);
                  errors++;
               end
               if (rsp_is_member !== e.member) begin
                  $display("%0t: is_member expected %0d actual %0d", $time, e.member,
                           rsp_is_member);
                  errors++;
               end
               if (rsp_last_of_run !== e.last) begin
                  $display("%0t: last_of_run expected %0d actual %0d", $time, e.last,
                           rsp_last_of_run);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_beat(req_action, req_item_value);
            req_beats++;
         end
         if (csr_valid && csr_ready) begin
            op_mode = csr_data;
            csr_beats++;
         end
      end
   end

   // Receiver stalls at random
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // Send one beat, with an optional idle gap first
   task automatic send_beat(logic [2:0] action, logic signed [31:0] v);
      int target;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_item_value <= v;
      target = req_beats + 1;
      do @(negedge clock); while (req_beats < target);
   endtask

   // Hold until every result is in, plus a margin for result-free beats
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      int target;
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= m;
      target = csr_beats + 1;
      do @(negedge clock); while (csr_beats < target);
      csr_valid <= 1'b0;
   endtask

   task automatic test_load_and_query();
      write_mode(MODE_UNION);
      send_beat(ACT_LOAD_A, 32'sh7fffffff);
      send_beat(ACT_LOAD_A, 32'sh80000000);
      send_beat(ACT_LOAD_A, 32'sd0);
      send_beat(ACT_LOAD_B, -32'sd1);
      send_beat(ACT_LOAD_B, 32'sd0);
      send_beat(ACT_QUERY, 32'sh80000000);
      send_beat(ACT_QUERY, -32'sd1);
      send_beat(ACT_RUN, 32'sd0);
   endtask

   task automatic test_operations();
      write_mode(MODE_INTER);
      send_beat(ACT_RUN, 32'sd0);
      write_mode(MODE_DIFF);
      send_beat(ACT_RUN, 32'sd0);
      write_mode(MODE_NONE);
      send_beat(ACT_RUN, 32'sd0);
   endtask

   task automatic test_special_cases();
      // Unknown actions, empty run, tie in size, repeated element
      write_mode(MODE_UNION);
      send_beat(3'd5, 32'sd9);
      send_beat(3'd6, 32'sd9);
      send_beat(3'd7, 32'sd9);
      send_beat(ACT_CLEAR, 32'sd0);
      send_beat(ACT_RUN, 32'sd0);
      send_beat(ACT_QUERY, 32'sd0);
      send_beat(ACT_LOAD_A, 32'sd5);
      send_beat(ACT_LOAD_A, 32'sd5);
      send_beat(ACT_LOAD_B, 32'sd3);
      send_beat(ACT_LOAD_B, 32'sd5);
      send_beat(ACT_RUN, 32'sd0);
   endtask

   function automatic logic signed [31:0] pick_value(bit narrow);
      if (narrow) return $signed($urandom_range(0, 12)) - 32'sd6;
      return $signed($urandom);
   endfunction

   // One random sequence: optional clear, loads of both sets, optional queries, run
   task automatic random_sequence();
      bit narrow;
      int na;
      int nb;
      narrow = ($urandom_range(99) < 70);
      if ($urandom_range(11) == 0) begin
         na = $urandom_range(30, 34); nb = $urandom_range(0, 34);
      end else begin
         na = $urandom_range(0, 6); nb = $urandom_range(0, 6);
      end
      if ($urandom_range(9) != 0) send_beat(ACT_CLEAR, pick_value(0));
      while (na > 0 || nb > 0) begin
         if (nb == 0 || (na > 0 && $urandom_range(1))) begin
            send_beat(ACT_LOAD_A, pick_value(narrow)); na--;
         end else begin
            send_beat(ACT_LOAD_B, pick_value(narrow)); nb--;
         end
      end
      repeat ($urandom_range(0, 2)) send_beat(ACT_QUERY, pick_value(narrow));
      if ($urandom_range(9) == 0) send_beat(3'($urandom_range(5, 7)), pick_value(0));
      send_beat(ACT_RUN, pick_value(0));
   endtask

   task automatic test_random(int idle, int stall, int n_items);
      int start;
      idle_pct = idle; stall_pct = stall;
      start = req_beats;
      while (req_beats - start < n_items) begin
         if ($urandom_range(5) == 0) write_mode(2'($urandom_range(0, 3)));
         random_sequence();
      end
   endtask

   initial begin
      errors = 0; req_beats = 0; csr_beats = 0; cycles = 0;
      idle_pct = 0; stall_pct = 0;
      size_a = 0; size_b = 0; op_mode = MODE_UNION;
      reset = 1'b1;
      req_valid = 1'b0; req_action = ACT_CLEAR; req_item_value = '0;
      rsp_ready = 1'b1; csr_valid = 1'b0; csr_data = MODE_UNION;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_and_query();
      test_operations();
      test_special_cases();
      test_random(0, 0, 100);
      test_random(85, 0, 100);
      wait_drained();
      test_random(0, 85, 100);
      test_random(6, 6, 110);
      write_mode(MODE_DIFF);
      wait_drained();
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (pending_results.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
